FILE: rtl/ecu_pkg.sv
// ----------------------------------------------------------------------------
// ecu_pkg: shared definitions of the easing curve unit
// Selector codes, curve kinds, pipeline control types and the rounding and
// saturation helpers used by the datapath stages.
// ----------------------------------------------------------------------------
package ecu_pkg;

  typedef enum logic [2:0] {
    ACT_LINEAR      = 3'd0,
    ACT_IN_SINE     = 3'd1,
    ACT_OUT_SINE    = 3'd2,
    ACT_INOUT_SINE  = 3'd3,
    ACT_IN_BACK     = 3'd4,
    ACT_OUT_BACK    = 3'd5,
    ACT_INOUT_BACK  = 3'd6,
    ACT_LINEAR_ALT  = 3'd7
  } ecu_action_e;

  typedef enum logic [2:0] {
    KIND_LINEAR     = 3'd0,
    KIND_SIN_IN     = 3'd1,
    KIND_SIN_OUT    = 3'd2,
    KIND_SIN_INOUT  = 3'd3,
    KIND_BACK       = 3'd4
  } ecu_kind_e;

  typedef enum logic [1:0] {
    OFFS_NONE = 2'd0,
    OFFS_ONE  = 2'd1,
    OFFS_TWO  = 2'd2
  } ecu_offs_e;

  typedef struct packed {
    ecu_kind_e kind;
    logic      neg;
    ecu_offs_e offs;
    logic      halve;
  } ecu_ctl_t;

  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
  } ecu_en_t;

  localparam logic [63:0]        HALF_PI_Q30 = 64'd1686629713;
  localparam logic signed [63:0] BACK_S_Q30  = 64'sd1827057613;
  localparam logic signed [63:0] BACK_S2_Q30 = 64'sd2786262860;
  localparam logic signed [63:0] OUT_MAX     = 64'sd65535;
  localparam logic signed [63:0] OUT_MIN     = -64'sd65536;
  localparam logic [16:0]        OUT_MAX_BITS = 17'h0FFFF;
  localparam logic [16:0]        OUT_MIN_BITS = 17'h10000;

  // Right shift that rounds to nearest, with ties away from zero.
  function automatic logic signed [63:0] ecu_rshr(input logic signed [63:0] v,
                                                  input int unsigned sh);
    logic [63:0] half;
    logic [63:0] mag;
    half = (sh > 0) ? (64'd1 << (sh - 1)) : 64'd0;
    mag  = 64'd0 - unsigned'(v);
    if (!v[63]) begin
      return signed'((unsigned'(v) + half) >> sh);
    end
    return -signed'((mag + half) >> sh);
  endfunction

  function automatic logic [16:0] ecu_sat17(input logic signed [63:0] v);
    if (v > OUT_MAX) begin
      return OUT_MAX_BITS;
    end
    if (v < OUT_MIN) begin
      return OUT_MIN_BITS;
    end
    return v[16:0];
  endfunction

endpackage

FILE: rtl/ecu_sine_rom.sv
// ----------------------------------------------------------------------------
// ecu_sine_rom: quarter-wave sine table
// Constant table of sin(k*pi/(2N)) for k = 0..N, built at elaboration, with
// two read ports for the interpolation end points.
// ----------------------------------------------------------------------------
module ecu_sine_rom #(
  parameter int unsigned SINE_TABLE_ENTRIES = 256,
  parameter int unsigned FRACTION_BITS      = 15
) (
  input  logic [$clog2(SINE_TABLE_ENTRIES+1)-1:0] idx_i,
  output logic [FRACTION_BITS:0]                  lo_o,
  output logic [FRACTION_BITS:0]                  hi_o
);
  import ecu_pkg::*;

  localparam int unsigned IdxW      = $clog2(SINE_TABLE_ENTRIES + 1);
  localparam int unsigned EntW      = FRACTION_BITS + 1;
  localparam logic [63:0] Entries64 = 64'(SINE_TABLE_ENTRIES);
  localparam logic [63:0] OneEnt    = 64'd1 << FRACTION_BITS;
  localparam logic [63:0] TaylorDen [8] = '{
    64'd6 << 30, 64'd20 << 30, 64'd42 << 30, 64'd72 << 30,
    64'd110 << 30, 64'd156 << 30, 64'd210 << 30, 64'd272 << 30
  };
  localparam logic [63:0] TaylorHalf [8] = '{
    64'd3 << 30, 64'd10 << 30, 64'd21 << 30, 64'd36 << 30,
    64'd55 << 30, 64'd78 << 30, 64'd105 << 30, 64'd136 << 30
  };

  function automatic logic [63:0] rom_entry(input int unsigned k);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic signed [63:0] v;
    x    = (64'(k) * HALF_PI_Q30 + (Entries64 >> 1)) / Entries64;
    x2   = (x * x + (64'd1 << 29)) >> 30;
    term = x;
    sum  = signed'(x);
    for (int n = 0; n < 8; n++) begin
      term = (term * x2 + TaylorHalf[n]) / TaylorDen[n];
      if (n % 2 == 0) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    v = ecu_rshr(sum, 30 - FRACTION_BITS);
    if (v < 0) begin
      v = '0;
    end
    if (v > signed'(OneEnt)) begin
      v = signed'(OneEnt);
    end
    return unsigned'(v);
  endfunction

  logic [EntW-1:0] rom [SINE_TABLE_ENTRIES+1];

  for (genvar k = 0; k <= SINE_TABLE_ENTRIES; k++) begin : g_rom
    assign rom[k] = EntW'(rom_entry(k));
  end

  assign lo_o = rom[idx_i];
  assign hi_o = (idx_i >= IdxW'(SINE_TABLE_ENTRIES)) ? rom[SINE_TABLE_ENTRIES]
                                                     : rom[idx_i + IdxW'(1)];

endmodule

FILE: rtl/ecu_sine_path.sv
// ----------------------------------------------------------------------------
// ecu_sine_path: interpolated quarter-wave sine
// Three register stages: table address and fraction, table read, then the
// interpolation product. The final rounding add is left to the next stage.
// ----------------------------------------------------------------------------
module ecu_sine_path #(
  parameter int unsigned SINE_TABLE_ENTRIES = 256,
  parameter int unsigned FRACTION_BITS      = 15
) (
  input  logic                   clk_i,
  input  ecu_pkg::ecu_en_t       en_i,
  input  logic [FRACTION_BITS:0] p_i,
  output logic [FRACTION_BITS:0] sin_o
);
  import ecu_pkg::*;

  localparam int unsigned F    = FRACTION_BITS;
  localparam int unsigned IdxW = $clog2(SINE_TABLE_ENTRIES + 1);
  localparam int unsigned PosW = F + 1 + IdxW;

  logic [PosW-1:0]       pos;
  logic [IdxW:0]         idx_raw;
  logic [IdxW-1:0]       idx_d, idx_q;
  logic [F-1:0]          frac_q, frac2_q;
  logic [F:0]            lo, hi;
  logic [F:0]            lo_q, lo2_q;
  logic signed [F+1:0]   diff_d, diff_q;
  logic signed [2*F+2:0] prod_d, prod_q;

  assign pos     = p_i * PosW'(SINE_TABLE_ENTRIES);
  assign idx_raw = pos[PosW-1:F];
  assign idx_d   = (idx_raw >= (IdxW+1)'(SINE_TABLE_ENTRIES)) ?
                   IdxW'(SINE_TABLE_ENTRIES) : idx_raw[IdxW-1:0];

  ecu_sine_rom #(
    .SINE_TABLE_ENTRIES(SINE_TABLE_ENTRIES),
    .FRACTION_BITS     (FRACTION_BITS)
  ) u_rom (
    .idx_i(idx_q),
    .lo_o (lo),
    .hi_o (hi)
  );

  assign diff_d = signed'({1'b0, hi}) - signed'({1'b0, lo});
  assign prod_d = diff_q * signed'({1'b0, frac2_q});

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      idx_q  <= idx_d;
      frac_q <= pos[F-1:0];
    end
    if (en_i.s3) begin
      lo_q    <= lo;
      diff_q  <= diff_d;
      frac2_q <= frac_q;
    end
    if (en_i.s4) begin
      lo2_q  <= lo_q;
      prod_q <= prod_d;
    end
  end

  assign sin_o = (F+1)'(64'(lo2_q) + unsigned'(ecu_rshr(64'(prod_q), F)));

endmodule

FILE: rtl/ecu_back_path.sv
// ----------------------------------------------------------------------------
// ecu_back_path: back-curve cubic x^2 * ((k + 1) * x +/- k)
// Three register stages: the square and the linear factor, their rounding,
// then the final product. The closing rounding is left to the next stage.
// ----------------------------------------------------------------------------
module ecu_back_path #(
  parameter int unsigned FRACTION_BITS = 15
) (
  input  logic                          clk_i,
  input  ecu_pkg::ecu_en_t              en_i,
  input  logic signed [FRACTION_BITS+1:0] x_i,
  input  logic                          big_k_i,
  input  logic                          sgn_pos_i,
  output logic signed [FRACTION_BITS+3:0] cub_o
);
  import ecu_pkg::*;

  localparam int unsigned F   = FRACTION_BITS;
  localparam int unsigned XW  = F + 2;
  localparam int unsigned KW  = F + 3;
  localparam int unsigned MW  = 2 * F + 6;
  localparam int unsigned CW  = F + 4;
  localparam logic signed [63:0] SVal  = ecu_rshr(BACK_S_Q30, 30 - F);
  localparam logic signed [63:0] S2Val = ecu_rshr(BACK_S2_Q30, 30 - F);
  localparam logic signed [63:0] One64 = 64'sd1 <<< F;
  localparam logic [KW-1:0]        SPlusOne  = KW'(SVal + One64);
  localparam logic [KW-1:0]        S2PlusOne = KW'(S2Val + One64);
  localparam logic signed [MW-1:0] SOne      = MW'(SVal * One64);
  localparam logic signed [MW-1:0] S2One     = MW'(S2Val * One64);

  logic signed [KW:0]     kp1;
  logic signed [MW-1:0]   kone;
  logic signed [2*XW-1:0] sqp_d, sqp_q;
  logic signed [MW-1:0]   inner_d, inner_q;
  logic [F:0]             sq_d, sq_q;
  logic signed [CW-1:0]   inr_d, inr_q;
  logic signed [MW-1:0]   prod_d, prod_q;

  assign kp1     = signed'({1'b0, (big_k_i ? S2PlusOne : SPlusOne)});
  assign kone    = big_k_i ? S2One : SOne;
  assign sqp_d   = x_i * x_i;
  assign inner_d = x_i * kp1 + (sgn_pos_i ? kone : -kone);
  assign sq_d    = (F+1)'(ecu_rshr(64'(sqp_q), F));
  assign inr_d   = CW'(ecu_rshr(64'(inner_q), F));
  assign prod_d  = signed'({1'b0, sq_q}) * inr_q;

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      sqp_q   <= sqp_d;
      inner_q <= inner_d;
    end
    if (en_i.s3) begin
      sq_q  <= sq_d;
      inr_q <= inr_d;
    end
    if (en_i.s4) begin
      prod_q <= prod_d;
    end
  end

  assign cub_o = CW'(ecu_rshr(64'(prod_q), F));

endmodule

FILE: rtl/easing_curve_unit.sv
// ----------------------------------------------------------------------------
// easing_curve_unit: sine and back easing curves over normalised time
// Throughput: one item per cycle while the output is accepted; each of the five
// stages holds its item while the stage after it is full and cannot move on, so
// a stalled output loses nothing.
// Reset clears every stage valid bit; the sine table is constant logic.
// ----------------------------------------------------------------------------
module easing_curve_unit #(
  parameter int unsigned SINE_TABLE_ENTRIES = 256,
  parameter int unsigned FRACTION_BITS      = 15
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  action_i,
  input  logic [15:0] time_req_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [16:0] eased_o
);
  import ecu_pkg::*;

  localparam int unsigned F   = FRACTION_BITS;
  localparam int unsigned TW  = F + 1;
  localparam int unsigned XW  = F + 2;
  localparam int unsigned CW  = F + 4;
  localparam int unsigned RW  = F + 6;
  localparam int unsigned One = 1 << F;
  localparam logic [TW-1:0]        OneT  = TW'(One);
  localparam logic [TW:0]          OneT2 = (TW+1)'(One);
  localparam logic [TW:0]          TwoT2 = (TW+1)'(2 * One);
  localparam logic signed [XW-1:0] OneX  = XW'(One);
  localparam logic signed [RW-1:0] OneR  = RW'(One);
  localparam logic signed [RW-1:0] TwoR  = RW'(2 * One);

  logic [4:0] valid_q;
  logic [4:0] en;
  ecu_en_t    path_en;

  logic [TW-1:0]        t_c;
  logic [TW:0]          two_t;
  ecu_ctl_t             ctl_d;
  logic [TW-1:0]        p_d;
  logic signed [XW-1:0] x_d;
  logic                 big_k_d, sgn_pos_d;

  ecu_ctl_t             ctl1_q, ctl2_q, ctl3_q, ctl4_q;
  logic [TW-1:0]        t1_q, t2_q, t3_q, t4_q;
  logic [TW-1:0]        p1_q;
  logic signed [XW-1:0] x1_q;
  logic                 big_k1_q, sgn_pos1_q;

  logic [TW-1:0]        sin_val;
  logic signed [CW-1:0] cub;
  logic signed [RW-1:0] acc, res;
  logic [16:0]          eased_d, eased_q;

  assign en[4] = !valid_q[4] || out_ready_i;
  assign en[3] = !valid_q[3] || en[4];
  assign en[2] = !valid_q[2] || en[3];
  assign en[1] = !valid_q[1] || en[2];
  assign en[0] = !valid_q[0] || en[1];
  assign in_ready_o = en[0];
  assign out_valid_o = valid_q[4];
  assign eased_o = eased_q;

  assign path_en.s2 = en[1];
  assign path_en.s3 = en[2];
  assign path_en.s4 = en[3];

  assign t_c   = (32'(time_req_i) > 32'(One)) ? OneT : TW'(time_req_i);
  assign two_t = {t_c, 1'b0};

  always_comb begin
    ctl_d.kind  = KIND_LINEAR;
    ctl_d.neg   = 1'b0;
    ctl_d.offs  = OFFS_NONE;
    ctl_d.halve = 1'b0;
    p_d         = t_c;
    x_d         = signed'({1'b0, t_c});
    big_k_d     = 1'b0;
    sgn_pos_d   = 1'b0;
    unique case (ecu_action_e'(action_i))
      ACT_LINEAR, ACT_LINEAR_ALT: begin
        ctl_d.kind = KIND_LINEAR;
      end
      ACT_IN_SINE: begin
        ctl_d.kind = KIND_SIN_IN;
        p_d        = OneT - t_c;
      end
      ACT_OUT_SINE: begin
        ctl_d.kind = KIND_SIN_OUT;
      end
      ACT_INOUT_SINE: begin
        ctl_d.kind = KIND_SIN_INOUT;
        if (two_t <= OneT2) begin
          p_d = TW'(OneT2 - two_t);
        end else begin
          p_d       = TW'(two_t - OneT2);
          ctl_d.neg = 1'b1;
        end
      end
      ACT_IN_BACK: begin
        ctl_d.kind = KIND_BACK;
      end
      ACT_OUT_BACK: begin
        ctl_d.kind = KIND_BACK;
        ctl_d.offs = OFFS_ONE;
        x_d        = signed'({1'b0, t_c}) - OneX;
        sgn_pos_d  = 1'b1;
      end
      ACT_INOUT_BACK: begin
        ctl_d.kind  = KIND_BACK;
        ctl_d.halve = 1'b1;
        big_k_d     = 1'b1;
        if (two_t < OneT2) begin
          x_d = signed'(two_t);
        end else begin
          x_d        = signed'(two_t - TwoT2);
          ctl_d.offs = OFFS_TWO;
          sgn_pos_d  = 1'b1;
        end
      end
    endcase
  end

  ecu_sine_path #(
    .SINE_TABLE_ENTRIES(SINE_TABLE_ENTRIES),
    .FRACTION_BITS     (FRACTION_BITS)
  ) u_sine (
    .clk_i(clk_i),
    .en_i (path_en),
    .p_i  (p1_q),
    .sin_o(sin_val)
  );

  ecu_back_path #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_back (
    .clk_i    (clk_i),
    .en_i     (path_en),
    .x_i      (x1_q),
    .big_k_i  (big_k1_q),
    .sgn_pos_i(sgn_pos1_q),
    .cub_o    (cub)
  );

  always_comb begin
    acc = RW'(cub);
    unique case (ctl4_q.offs)
      OFFS_NONE: acc = RW'(cub);
      OFFS_ONE:  acc = RW'(cub) + OneR;
      OFFS_TWO:  acc = RW'(cub) + TwoR;
      default:   acc = RW'(cub);
    endcase
    unique case (ctl4_q.kind)
      KIND_LINEAR:  res = signed'(RW'(t4_q));
      KIND_SIN_IN:  res = OneR - signed'(RW'(sin_val));
      KIND_SIN_OUT: res = signed'(RW'(sin_val));
      KIND_SIN_INOUT: begin
        if (ctl4_q.neg) begin
          res = RW'(ecu_rshr(64'(OneR + signed'(RW'(sin_val))), 1));
        end else begin
          res = RW'(ecu_rshr(64'(OneR - signed'(RW'(sin_val))), 1));
        end
      end
      KIND_BACK: begin
        if (ctl4_q.halve) begin
          res = RW'(ecu_rshr(64'(acc), 1));
        end else begin
          res = acc;
        end
      end
      default: res = signed'(RW'(t4_q));
    endcase
    eased_d = ecu_sat17(64'(res));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) valid_q[0] <= in_valid_i;
      if (en[1]) valid_q[1] <= valid_q[0];
      if (en[2]) valid_q[2] <= valid_q[1];
      if (en[3]) valid_q[3] <= valid_q[2];
      if (en[4]) valid_q[4] <= valid_q[3];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      ctl1_q     <= ctl_d;
      t1_q       <= t_c;
      p1_q       <= p_d;
      x1_q       <= x_d;
      big_k1_q   <= big_k_d;
      sgn_pos1_q <= sgn_pos_d;
    end
    if (en[1]) begin
      ctl2_q <= ctl1_q;
      t2_q   <= t1_q;
    end
    if (en[2]) begin
      ctl3_q <= ctl2_q;
      t3_q   <= t2_q;
    end
    if (en[3]) begin
      ctl4_q <= ctl3_q;
      t4_q   <= t3_q;
    end
    if (en[4]) begin
      eased_q <= eased_d;
    end
  end

  // An empty output stage means the whole pipeline can move.
  a_ready_when_drained : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled while the output stage was empty");

  a_result_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q[3] && en[4]) |=> out_valid_o)
    else $error("an item in the last datapath stage was dropped");

  a_no_invented : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !valid_q[3]) |=> !out_valid_o)
    else $error("output valid without an item behind the transfer");

endmodule

FILE: verif/easing_curve_checker.sv
// ----------------------------------------------------------------------------
// easing_curve_checker: prediction and comparison for the easing curve unit
// Watches both channels. Each input transfer yields one predicted eased value,
// which is computed bit-exactly in fixed point from a locally built quarter-wave
// sine table. Output transfers are compared in order against those values.
// ----------------------------------------------------------------------------
module easing_curve_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [2:0]  action_i,
  input  logic [15:0] time_req_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [16:0] eased_i,
  output int          fault_count_o,
  output int          pending_o
);
  import ecu_pkg::*;

  localparam longint STEPS = 256;
  localparam int     FRAC = 15;
  localparam longint ONE = longint'(1) << FRAC;
  localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
  localparam longint BACK_Q30 = 64'sd1827057613;
  localparam longint BACK_INOUT_Q30 = 64'sd2786262860;
  localparam longint EASED_MAX = 65535;
  localparam longint EASED_MIN = -65536;
  localparam int     REPORT_LIMIT = 10;

  typedef struct {
    ecu_action_e act;
    logic [15:0] tq;
    logic [16:0] eased;
  } eased_due_t;

  eased_due_t eased_due_q[$];
  longint     sine_q15[STEPS+1];
  longint     back_k;
  longint     back_inout_k;
  int         fault_total;

  // Rounds to nearest with ties away from zero.
  function automatic longint round_shift(input longint v, input int sh);
    longint unsigned half;
    longint unsigned mag;
    half = (sh > 0) ? (64'd1 << (sh - 1)) : 64'd0;
    if (v >= 0) begin
      return $signed(($unsigned(v) + half) >> sh);
    end
    mag = $unsigned(-v);
    return -$signed((mag + half) >> sh);
  endfunction

  function automatic longint taylor_sine_q30(input longint unsigned x);
    longint unsigned x2;
    longint unsigned term;
    longint unsigned den;
    longint          acc;
    int              n;
    x2 = (x * x + (64'd1 << 29)) >> 30;
    term = x;
    acc = $signed(x);
    for (n = 1; n <= 8; n++) begin
      den = 64'((2 * n) * (2 * n + 1)) << 30;
      term = (term * x2 + den / 2) / den;
      if (n % 2 == 1) begin
        acc = acc - $signed(term);
      end else begin
        acc = acc + $signed(term);
      end
    end
    return acc;
  endfunction

  function automatic longint quarter_sine(input longint p);
    longint pos;
    longint frac;
    longint lo;
    longint hi;
    int     idx;
    if (p <= 0) begin
      return sine_q15[0];
    end
    if (p >= ONE) begin
      return sine_q15[STEPS];
    end
    pos  = p * STEPS;
    idx  = int'(pos >> FRAC);
    frac = pos & (ONE - 1);
    lo   = sine_q15[idx];
    hi   = sine_q15[idx + 1];
    return lo + round_shift((hi - lo) * frac, FRAC);
  endfunction

  // x^2 * ((k + 1) * x +/- k) in the working fraction format.
  function automatic longint back_poly(input longint x, input longint k, input bit rising);
    longint sq;
    longint inner;
    sq    = round_shift(x * x, FRAC);
    inner = (k + ONE) * x + (rising ? k * ONE : -(k * ONE));
    return round_shift(sq * round_shift(inner, FRAC), FRAC);
  endfunction

  function automatic logic [16:0] eased_value(input ecu_action_e act, input logic [15:0] tq);
    longint t;
    longint r;
    longint c;
    t = longint'(tq);
    if (t > ONE) begin
      t = ONE;
    end
    case (act)
      ACT_IN_SINE: begin
        r = ONE - quarter_sine(ONE - t);
      end
      ACT_OUT_SINE: begin
        r = quarter_sine(t);
      end
      ACT_INOUT_SINE: begin
        c = (2 * t <= ONE) ? quarter_sine(ONE - 2 * t) : -quarter_sine(2 * t - ONE);
        r = round_shift(ONE - c, 1);
      end
      ACT_IN_BACK: begin
        r = back_poly(t, back_k, 1'b0);
      end
      ACT_OUT_BACK: begin
        r = back_poly(t - ONE, back_k, 1'b1) + ONE;
      end
      ACT_INOUT_BACK: begin
        if (2 * t < ONE) begin
          r = round_shift(back_poly(2 * t, back_inout_k, 1'b0), 1);
        end else begin
          r = round_shift(back_poly(2 * t - 2 * ONE, back_inout_k, 1'b1) + 2 * ONE, 1);
        end
      end
      default: begin
        r = t;
      end
    endcase
    if (r > EASED_MAX) begin
      r = EASED_MAX;
    end
    if (r < EASED_MIN) begin
      r = EASED_MIN;
    end
    return r[16:0];
  endfunction

  initial begin
    longint unsigned k;
    longint unsigned x;
    longint          v;
    for (k = 0; k <= STEPS; k++) begin
      x = (k * QUARTER_TURN_Q30 + STEPS / 2) / STEPS;
      v = round_shift(taylor_sine_q30(x), 30 - FRAC);
      if (v < 0) begin
        v = 0;
      end
      if (v > ONE) begin
        v = ONE;
      end
      sine_q15[k] = v;
    end
    back_k       = round_shift(BACK_Q30, 30 - FRAC);
    back_inout_k = round_shift(BACK_INOUT_Q30, 30 - FRAC);
    fault_total  = 0;
  end

  always @(posedge clk_i) begin
    eased_due_t due;
    if (!rst_ni) begin
      eased_due_q.delete();
      fault_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        due.act   = ecu_action_e'(action_i);
        due.tq    = time_req_i;
        due.eased = eased_value(due.act, due.tq);
        eased_due_q.push_back(due);
      end
      if (out_valid_i && out_ready_i) begin
        if (eased_due_q.size() == 0) begin
          fault_total++;
          if (fault_total <= REPORT_LIMIT) begin
            $display("unexpected output transfer: eased %h (%0d)", eased_i, $signed(eased_i));
          end
        end else begin
          due = eased_due_q.pop_front();
          if (due.eased !== eased_i) begin
            fault_total++;
            if (fault_total <= REPORT_LIMIT) begin
              $display("eased mismatch for %s time %h: expected %h (%0d) actual %h (%0d)",
                       due.act.name(), due.tq, due.eased, $signed(due.eased),
                       eased_i, $signed(eased_i));
            end
          end
        end
      end
      fault_count_o <= fault_total;
      pending_o <= eased_due_q.size();
    end
  end

endmodule

FILE: verif/tb_easing_curve_unit.sv
// ----------------------------------------------------------------------------
// tb_easing_curve_unit: stimulus and verdict for the easing curve unit
// Drives directed corner cases for every curve selector, then random times
// biased towards the curve boundaries, with random idling on both channels.
// A separate checker predicts and compares every output transfer.
// ----------------------------------------------------------------------------
module tb_easing_curve_unit;
  import ecu_pkg::*;

  localparam logic [15:0] TIME_ONE = 16'h8000;
  localparam logic [15:0] TIME_HALF = 16'h4000;
  localparam int RANDOM_ITEMS = 800;
  localparam int CALM_ITEMS = 120;
  localparam int WATCHDOG_LIMIT = 400;

  logic        clk_i;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  action;
  logic [15:0] time_req;
  logic        out_valid;
  logic        out_ready;
  logic [16:0] eased;
  int          fault_count;
  int          pending;
  int          idle_pct;
  int          stuck;

  easing_curve_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .action_i    (action),
    .time_req_i  (time_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .eased_o     (eased)
  );

  easing_curve_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .action_i      (action),
    .time_req_i    (time_req),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .eased_i       (eased),
    .fault_count_o (fault_count),
    .pending_o     (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic send_curve(input ecu_action_e act, input logic [15:0] tq);
    int gap;
    in_valid <= 1'b1;
    action <= act;
    time_req <= tq;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    if ($urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_time();
    case ($urandom_range(0, 9))
      5: return 16'($urandom_range(0, 48));
      6: return 16'($urandom_range(32720, 32768));
      7: return 16'($urandom_range(16352, 16416));
      8: return 16'($urandom_range(32769, 65535));
      9: return 16'($urandom);
      default: return 16'($urandom_range(0, 32768));
    endcase
  endfunction

  initial begin
    ecu_action_e act;
    in_valid <= 1'b0;
    action <= 3'd0;
    time_req <= 16'd0;
    rst_n <= 1'b0;
    idle_pct <= 20;
    repeat (7) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    act = act.first();
    do begin
      send_curve(act, 16'h0000);
      send_curve(act, TIME_ONE);
      act = act.next();
    end while (act != act.first());
    send_curve(ACT_INOUT_SINE, TIME_HALF);
    send_curve(ACT_INOUT_SINE, TIME_HALF + 16'd1);
    send_curve(ACT_INOUT_BACK, TIME_HALF - 16'd1);
    send_curve(ACT_INOUT_BACK, TIME_HALF);
    send_curve(ACT_LINEAR_ALT, 16'hFFFF);
    send_curve(ACT_IN_BACK, TIME_ONE + 16'd1);
    send_curve(ACT_OUT_SINE, 16'd1);
    send_curve(ACT_OUT_BACK, TIME_ONE - 16'd1);
    wait_drained();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2) begin
        wait_drained();
      end
      if (i >= RANDOM_ITEMS - CALM_ITEMS) begin
        idle_pct <= 0;
      end else if (i % 50 == 0) begin
        idle_pct <= 15 * $urandom_range(0, 3);
      end
      send_curve(ecu_action_e'($urandom_range(0, 7)), pick_time());
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (fault_count == 0 && pending == 0) begin
      $display("easing_curve_unit verification clean");
    end else begin
      $display("easing_curve_unit verification failed");
    end
    $finish;
  end

  initial begin
    out_ready <= 1'b1;
    @(posedge rst_n);
    forever begin
      @(posedge clk_i);
      if ($urandom_range(0, 99) < idle_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
        out_ready <= 1'b1;
      end
    end
  end

  // The count restarts on every transfer in either direction.
  initial begin
    stuck = 0;
    while (stuck < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stuck = 0;
      end else begin
        stuck++;
      end
    end
    $display("easing_curve_unit verification failed");
    $finish;
  end

endmodule
